[src/dmwbc_pkg.sv]
// Shared types and fixed constants of the direct-mapped write-back cache.
package dmwbc_pkg;

   localparam int AddrWidth   = 12;
   localparam int IoDataWidth = 32;

   typedef struct packed {
      logic                   cpu_read;
      logic                   cpu_write;
      logic [AddrWidth-1:0]   cpu_address;
      logic [IoDataWidth-1:0] cpu_write_data;
      logic                   flush_request;
      logic                   mem_ready;
      logic [IoDataWidth-1:0] mem_read_data;
   } request_type;

   typedef struct packed {
      logic                   cpu_ready;
      logic [IoDataWidth-1:0] cpu_read_data;
      logic                   mem_read;
      logic                   mem_write;
      logic [AddrWidth-1:0]   mem_address;
      logic [IoDataWidth-1:0] mem_write_data;
      logic                   save_all_pulse;
   } response_type;

   // One strobe per step of the per-tick sequence.
   typedef struct packed {
      logic capture;
      logic latch;
      logic divide;
      logic quotient;
      logic remainder;
      logic tag_read;
      logic word_read;
      logic execute;
   } cmd_type;

endpackage

[src/dmwbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dmwbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512,
   localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/dmwbc_ctrl.sv]
// Sequencer that walks each transfer through the datapath steps and owns the handshakes.
module dmwbc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dmwbc_pkg::cmd_type cmd
);
   import dmwbc_pkg::*;

   localparam logic [2:0] PHASE_IDLE      = 3'd0;
   localparam logic [2:0] PHASE_LATCH     = 3'd1;
   localparam logic [2:0] PHASE_DIVIDE    = 3'd2;
   localparam logic [2:0] PHASE_QUOTIENT  = 3'd3;
   localparam logic [2:0] PHASE_REMAINDER = 3'd4;
   localparam logic [2:0] PHASE_TAG       = 3'd5;
   localparam logic [2:0] PHASE_WORD      = 3'd6;
   localparam logic [2:0] PHASE_EXEC      = 3'd7;

   logic [2:0] phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      phase_in     = phase_ff;
      // drop the result once it transfers
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (phase_ff)
         PHASE_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               phase_in    = PHASE_LATCH;
            end
         end
         PHASE_LATCH: begin
            cmd.latch = 1'b1;
            phase_in  = PHASE_DIVIDE;
         end
         PHASE_DIVIDE: begin
            cmd.divide = 1'b1;
            phase_in   = PHASE_QUOTIENT;
         end
         PHASE_QUOTIENT: begin
            cmd.quotient = 1'b1;
            phase_in     = PHASE_REMAINDER;
         end
         PHASE_REMAINDER: begin
            cmd.remainder = 1'b1;
            phase_in      = PHASE_TAG;
         end
         PHASE_TAG: begin
            cmd.tag_read = 1'b1;
            phase_in     = PHASE_WORD;
         end
         PHASE_WORD: begin
            cmd.word_read = 1'b1;
            phase_in      = PHASE_EXEC;
         end
         PHASE_EXEC: begin
            // commit only when the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               phase_in     = PHASE_IDLE;
            end
         end
         default: begin
            phase_in = PHASE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (phase_ff != PHASE_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[src/dmwbc_datapath.sv]
// Cache state, address decode, line storage and per-tick result logic.
module dmwbc_datapath #(
   parameter int DATA_WIDTH     = 32,
   parameter int LINE_COUNT     = 32,
   parameter int WORDS_PER_LINE = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dmwbc_pkg::cmd_type      cmd,
   input  dmwbc_pkg::request_type  req_payload,
   output dmwbc_pkg::response_type rsp_payload
);
   import dmwbc_pkg::*;

   localparam int OFF_WIDTH      = $clog2(WORDS_PER_LINE);
   localparam int IDX_WIDTH      = $clog2(LINE_COUNT);
   localparam int TAG_COUNT      = (2 ** AddrWidth - 1) / WORDS_PER_LINE + 1;
   localparam int TAG_WIDTH      = $clog2(TAG_COUNT);
   localparam int RAM_ADDR_WIDTH = $clog2(LINE_COUNT * WORDS_PER_LINE);
   localparam int COPY_WIDTH     = (DATA_WIDTH < IoDataWidth) ? DATA_WIDTH : IoDataWidth;
   // reciprocal multiply: exact floor division over the whole operand range
   localparam int TAG_SHIFT      = AddrWidth + OFF_WIDTH;
   localparam int TAG_RECIP      = (2 ** TAG_SHIFT + WORDS_PER_LINE - 1) / WORDS_PER_LINE;
   localparam int TAG_PROD_WIDTH = TAG_SHIFT + TAG_WIDTH + 1;
   localparam int QUO_SHIFT      = TAG_WIDTH + IDX_WIDTH;
   localparam int QUO_RECIP      = (2 ** QUO_SHIFT + LINE_COUNT - 1) / LINE_COUNT;
   localparam int QUO_PROD_WIDTH = QUO_SHIFT + TAG_WIDTH + 1;

   function automatic logic [DATA_WIDTH-1:0] to_store(input logic [IoDataWidth-1:0] v);
      logic [DATA_WIDTH-1:0] r;
      r = '0;
      r[COPY_WIDTH-1:0] = v[COPY_WIDTH-1:0];
      return r;
   endfunction

   function automatic logic [IoDataWidth-1:0] to_io(input logic [DATA_WIDTH-1:0] v);
      logic [IoDataWidth-1:0] r;
      r = '0;
      r[COPY_WIDTH-1:0] = v[COPY_WIDTH-1:0];
      return r;
   endfunction

   request_type             in_ff;
   logic                    flush_active_ff, flush_active_in;
   logic                    held_rd_ff, held_rd_in;
   logic                    held_wr_ff, held_wr_in;
   logic [AddrWidth-1:0]    held_addr_ff, held_addr_in;
   logic [DATA_WIDTH-1:0]   held_data_ff, held_data_in;
   logic [TAG_WIDTH-1:0]    tag_ff, tag_in;
   logic [TAG_WIDTH-1:0]    quo_ff, quo_in;
   logic [OFF_WIDTH-1:0]    off_ff, off_in;
   logic [IDX_WIDTH-1:0]    idx_ff, idx_in;
   logic                    refill_busy_ff, refill_busy_in;
   logic                    awaiting_ff, awaiting_in;
   logic [IDX_WIDTH-1:0]    ptr_ff, ptr_in;
   logic                    save_next_ff, save_next_in;
   logic [OFF_WIDTH-1:0]    wc_ff, wc_in;
   logic [LINE_COUNT-1:0]   dirty_ff, dirty_in;
   logic [LINE_COUNT-1:0]   valid_ff, valid_in;
   response_type            rsp_ff, rsp_in;

   logic [TAG_PROD_WIDTH-1:0] tag_prod;
   logic [QUO_PROD_WIDTH-1:0] quo_prod;
   logic [AddrWidth-1:0]      tag_base;
   logic [TAG_WIDTH-1:0]      rem_full;
   logic                      flushing;
   logic [IDX_WIDTH-1:0]      line_sel;
   logic [RAM_ADDR_WIDTH-1:0] line_base;
   logic                      hit;
   logic                      wc_last;
   logic [OFF_WIDTH-1:0]      wc_next;
   logic [OFF_WIDTH-1:0]      word_off;
   logic [RAM_ADDR_WIDTH-1:0] word_rd_addr;
   logic [TAG_WIDTH-1:0]      tag_rdata;
   logic [DATA_WIDTH-1:0]     word_rdata;
   logic                      word_we;
   logic [RAM_ADDR_WIDTH-1:0] word_waddr;
   logic [DATA_WIDTH-1:0]     word_wdata;
   logic                      tag_we;
   logic                      flush_eff;
   logic                      mr;
   logic                      wb;
   logic                      advance;
   logic                      save_set;
   logic                      save_eff;
   response_type              resp;

   // address decode by reciprocal multiplies, spread over the divide, quotient and remainder steps
   assign tag_prod = TAG_PROD_WIDTH'(held_addr_ff) * TAG_PROD_WIDTH'(TAG_RECIP);
   assign quo_prod = QUO_PROD_WIDTH'(tag_ff) * QUO_PROD_WIDTH'(QUO_RECIP);
   assign tag_base = AddrWidth'(AddrWidth'(tag_ff) * AddrWidth'(WORDS_PER_LINE));
   assign rem_full = tag_ff - TAG_WIDTH'(TAG_WIDTH'(quo_ff) * TAG_WIDTH'(LINE_COUNT));

   assign flushing  = flush_active_ff & ~refill_busy_ff;
   assign line_sel  = flushing ? ptr_ff : idx_ff;
   assign line_base = RAM_ADDR_WIDTH'(RAM_ADDR_WIDTH'(line_sel) *
                                      RAM_ADDR_WIDTH'(WORDS_PER_LINE));
   assign hit       = valid_ff[line_sel] && (tag_rdata == tag_ff);
   assign wc_last   = (wc_ff == OFF_WIDTH'(WORDS_PER_LINE - 1));
   assign wc_next   = awaiting_ff ? OFF_WIDTH'(wc_ff + 1'b1) : wc_ff;
   assign word_off  = (!flushing && hit && !refill_busy_ff) ? off_ff : wc_ff;
   assign word_rd_addr = line_base + RAM_ADDR_WIDTH'(word_off);
   assign flush_eff = flush_active_ff | in_ff.flush_request;
   assign mr        = in_ff.mem_ready;

   always_comb begin
      flush_active_in = flush_active_ff;
      held_rd_in      = held_rd_ff;
      held_wr_in      = held_wr_ff;
      held_addr_in    = held_addr_ff;
      held_data_in    = held_data_ff;
      tag_in          = tag_ff;
      quo_in          = quo_ff;
      off_in          = off_ff;
      idx_in          = idx_ff;
      refill_busy_in  = refill_busy_ff;
      awaiting_in     = awaiting_ff;
      ptr_in          = ptr_ff;
      save_next_in    = save_next_ff;
      wc_in           = wc_ff;
      dirty_in        = dirty_ff;
      valid_in        = valid_ff;
      rsp_in          = rsp_ff;
      word_we         = 1'b0;
      word_waddr      = line_base + RAM_ADDR_WIDTH'(wc_ff);
      word_wdata      = to_store(in_ff.mem_read_data);
      tag_we          = 1'b0;
      wb              = 1'b0;
      advance         = 1'b0;
      save_set        = 1'b0;
      save_eff        = 1'b0;
      resp            = '0;
      resp.cpu_ready  = 1'b1;

      if (cmd.latch) begin
         flush_active_in = flush_eff;
         // take a new request only while neither refill nor flush is running
         if (!refill_busy_ff && (in_ff.cpu_read || in_ff.cpu_write) && !flush_eff) begin
            held_rd_in   = in_ff.cpu_read;
            held_wr_in   = in_ff.cpu_write;
            held_addr_in = in_ff.cpu_address;
            held_data_in = to_store(in_ff.cpu_write_data);
         end
      end

      if (cmd.divide) begin
         tag_in = tag_prod[TAG_SHIFT +: TAG_WIDTH];
      end

      if (cmd.quotient) begin
         quo_in = quo_prod[QUO_SHIFT +: TAG_WIDTH];
         off_in = OFF_WIDTH'(held_addr_ff - tag_base);
      end

      if (cmd.remainder) begin
         idx_in = IDX_WIDTH'(rem_full);
      end

      if (cmd.execute) begin
         if (flushing) begin
            resp.cpu_ready = 1'b0;
            if (dirty_ff[ptr_ff]) begin
               if (mr) begin
                  wb = 1'b1;
                  if (wc_last) begin
                     dirty_in[ptr_ff] = 1'b0;
                     wc_in            = '0;
                     advance          = 1'b1;
                  end else begin
                     wc_in = OFF_WIDTH'(wc_ff + 1'b1);
                  end
               end
            end else begin
               advance = 1'b1;
            end
         end else if (hit && !refill_busy_ff) begin
            if (held_wr_ff) begin
               word_we          = 1'b1;
               word_waddr       = line_base + RAM_ADDR_WIDTH'(off_ff);
               word_wdata       = held_data_ff;
               dirty_in[idx_ff] = 1'b1;
               held_wr_in       = 1'b0;
            end
            if (held_rd_ff) begin
               // a read paired with a write returns the word just written
               resp.cpu_read_data = to_io(held_wr_ff ? held_data_ff : word_rdata);
               held_rd_in         = 1'b0;
            end
         end else if (held_rd_ff || held_wr_ff || refill_busy_ff) begin
            refill_busy_in = 1'b1;
            resp.cpu_ready = 1'b0;
            if (dirty_ff[idx_ff]) begin
               if (mr) begin
                  wb = 1'b1;
                  if (wc_last) begin
                     dirty_in[idx_ff] = 1'b0;
                     wc_in            = '0;
                  end else begin
                     wc_in = OFF_WIDTH'(wc_ff + 1'b1);
                  end
               end
            end else if (mr) begin
               if (awaiting_ff) begin
                  word_we = 1'b1;
               end
               if (awaiting_ff && wc_last) begin
                  tag_we           = 1'b1;
                  valid_in[idx_ff] = 1'b1;
                  wc_in            = '0;
                  awaiting_in      = 1'b0;
                  refill_busy_in   = 1'b0;
               end else begin
                  resp.mem_read    = 1'b1;
                  resp.mem_address = tag_base + AddrWidth'(wc_next);
                  awaiting_in      = 1'b1;
                  wc_in            = wc_next;
               end
            end
         end

         if (wb) begin
            resp.mem_write      = 1'b1;
            resp.mem_address    = AddrWidth'(AddrWidth'(tag_rdata) *
                                              AddrWidth'(WORDS_PER_LINE)) + AddrWidth'(wc_ff);
            resp.mem_write_data = to_io(word_rdata);
         end

         if (advance) begin
            if (ptr_ff == IDX_WIDTH'(LINE_COUNT - 1)) begin
               ptr_in          = '0;
               flush_active_in = 1'b0;
               save_set        = 1'b1;
            end else begin
               ptr_in = IDX_WIDTH'(ptr_ff + 1'b1);
            end
         end

         // the pulse may fall on the very tick the flush ends
         save_eff = save_next_ff | save_set;
         if (save_eff && mr) begin
            resp.save_all_pulse = 1'b1;
            save_next_in        = 1'b0;
         end else begin
            save_next_in = save_eff;
         end

         rsp_in = resp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_active_ff <= 1'b0;
         held_rd_ff      <= 1'b0;
         held_wr_ff      <= 1'b0;
         held_addr_ff    <= '0;
         held_data_ff    <= '0;
         refill_busy_ff  <= 1'b0;
         awaiting_ff     <= 1'b0;
         ptr_ff          <= '0;
         save_next_ff    <= 1'b0;
         wc_ff           <= '0;
         dirty_ff        <= '0;
         valid_ff        <= '0;
      end else begin
         flush_active_ff <= flush_active_in;
         held_rd_ff      <= held_rd_in;
         held_wr_ff      <= held_wr_in;
         held_addr_ff    <= held_addr_in;
         held_data_ff    <= held_data_in;
         refill_busy_ff  <= refill_busy_in;
         awaiting_ff     <= awaiting_in;
         ptr_ff          <= ptr_in;
         save_next_ff    <= save_next_in;
         wc_ff           <= wc_in;
         dirty_ff        <= dirty_in;
         valid_ff        <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ff <= req_payload;
      end
      tag_ff <= tag_in;
      quo_ff <= quo_in;
      off_ff <= off_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   dmwbc_ram #(
      .WIDTH (TAG_WIDTH),
      .DEPTH (LINE_COUNT)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (idx_ff),
      .wr_data (tag_ff),
      .rd_en   (cmd.tag_read),
      .rd_addr (line_sel),
      .rd_data (tag_rdata)
   );

   dmwbc_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (LINE_COUNT * WORDS_PER_LINE)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (word_we),
      .wr_addr (word_waddr),
      .wr_data (word_wdata),
      .rd_en   (cmd.word_read),
      .rd_addr (word_rd_addr),
      .rd_data (word_rdata)
   );

   assign rsp_payload = rsp_ff;

endmodule

[src/direct_mapped_writeback_cache_top.sv]
// Top level of the direct-mapped write-back cache.
// Each transfer on req_ carries one clock tick of the processor and backing-memory
// interfaces, and each produces exactly one transfer on rsp_ with that tick's outputs.
// The cache holds LINE_COUNT lines of WORDS_PER_LINE words; the tag is the address
// divided by WORDS_PER_LINE and the line index is the tag modulo LINE_COUNT. Hits are
// served in the tick that carries them; misses write back a dirty line and refill it
// one word per ready tick; a flush writes back every dirty line and then pulses
// save_all_pulse. After an item is accepted, the sequencer steps through request latch,
// three address-decode steps, a tag RAM read, a line-word RAM read and the commit, which
// registers the result for rsp_; one step per cycle, the commit being held while the output
// register is full and stalled, and a new item is accepted only once it is back in idle.
// req_stall is high while an item is in flight; a finished result waits in the output
// register, and the next item may be accepted while it does; that next item then holds
// in its commit step until the output register is free.
module direct_mapped_writeback_cache_top #(
   parameter int DATA_WIDTH     = 32,
   parameter int LINE_COUNT     = 32,
   parameter int WORDS_PER_LINE = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  dmwbc_pkg::request_type  req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output dmwbc_pkg::response_type rsp_payload
);
   import dmwbc_pkg::*;

   cmd_type cmd;

   dmwbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   dmwbc_datapath #(
      .DATA_WIDTH     (DATA_WIDTH),
      .LINE_COUNT     (LINE_COUNT),
      .WORDS_PER_LINE (WORDS_PER_LINE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule
